FILE: rtl/core/smct_pkg.sv
// Shared types, constants and the cursor clip function of the serial mouse
// cursor tracker. No dependencies; imported by every module of the block.
package smct_pkg;

  // Cursor register width and the fixed widths of the ports
  localparam int POS_BITS   = 10;
  localparam int POS_OUT_W  = 10;
  localparam int SIZE_W     = 11;
  localparam int DELTA_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam int RESET_WIDTH  = 320;
  localparam int RESET_HEIGHT = 240;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_BUTTONS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES     = 3'd5;

  // Position of the next byte within a packet
  localparam logic [1:0] IDX_DX   = 2'd0;
  localparam logic [1:0] IDX_DY   = 2'd1;
  localparam logic [1:0] IDX_DONE = 2'd2;

  // Bits of a received byte
  localparam int BIT_SYNC = 6;
  localparam int BIT_B5   = 5;
  localparam int BIT_B4   = 4;

  // Width for the signed clip arithmetic: holds size, cap and pos + delta
  localparam int CALC_W = (POS_BITS + 2 > SIZE_W + 1) ? POS_BITS + 2 : SIZE_W + 1;

  typedef struct packed {
    logic [POS_BITS-1:0]      col;
    logic [POS_BITS-1:0]      row;
    logic                     left_down;
    logic                     right_down;
    logic                     moved;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
  } result_t;

  typedef struct packed {
    logic [SIZE_W-1:0] screen_width;
    logic [SIZE_W-1:0] screen_height;
    logic              swap_buttons;
    logic              invert_x;
    logic              invert_y;
    logic              swap_axes;
  } cfg_t;

  // Add a signed delta to a position and clamp to [0, size-1]; a size of
  // zero acts as one, a size beyond the cursor range saturates to it.
  function automatic logic [POS_BITS-1:0] move_clip(
    input logic [POS_BITS-1:0]       pos,
    input logic signed [DELTA_W-1:0] delta,
    input logic [SIZE_W-1:0]         size
  );
    logic signed [CALC_W-1:0] sz;
    logic signed [CALC_W-1:0] cap;
    logic signed [CALC_W-1:0] lim;
    logic signed [CALC_W-1:0] p;
    sz  = CALC_W'(size);
    cap = CALC_W'(1) << POS_BITS;
    if (sz == '0) begin
      sz = CALC_W'(1);
    end
    if (sz > cap) begin
      sz = cap;
    end
    lim = sz - CALC_W'(1);
    p   = CALC_W'(pos) + CALC_W'(delta);
    if (p < 0) begin
      p = '0;
    end
    if (p > lim) begin
      p = lim;
    end
    return POS_BITS'(p);
  endfunction

endpackage

FILE: rtl/core/smct_cfg.sv
// Configuration register file of the serial mouse cursor tracker.
// Depends on smct_pkg for the register indexes and cfg_t.
module smct_cfg
  import smct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  cfg_ready,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= SIZE_W'(RESET_WIDTH);
      cfg.screen_height <= SIZE_W'(RESET_HEIGHT);
      cfg.swap_buttons  <= 1'b0;
      cfg.invert_x      <= 1'b0;
      cfg.invert_y      <= 1'b0;
      cfg.swap_axes     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  cfg.screen_width  <= SIZE_W'(cfg_data);
        REG_SCREEN_HEIGHT: cfg.screen_height <= SIZE_W'(cfg_data);
        REG_SWAP_BUTTONS:  cfg.swap_buttons  <= cfg_data[0];
        REG_INVERT_X:      cfg.invert_x      <= cfg_data[0];
        REG_INVERT_Y:      cfg.invert_y      <= cfg_data[0];
        REG_SWAP_AXES:     cfg.swap_axes     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/smct_tracker.sv
// Packet assembly and cursor update: packet state registers and the
// single-pass next-state logic for one byte. Depends on smct_pkg.
module smct_tracker
  import smct_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic [7:0]   rx,
  input  cfg_t         cfg,
  output result_t      res
);

  logic [1:0]               byte_index, byte_index_next;
  logic                     left_button, left_button_next;
  logic                     right_button, right_button_next;
  logic [DELTA_W-1:0]       delta_x_acc, delta_x_acc_next;
  logic [DELTA_W-1:0]       delta_y_acc, delta_y_acc_next;
  logic [POS_BITS-1:0]      cur_col, cur_col_next;
  logic [POS_BITS-1:0]      cur_row, cur_row_next;
  logic                     moved;
  logic [DELTA_W-1:0]       dx_merge, dy_merge;
  logic signed [DELTA_W-1:0] dx, dy;

  assign dx_merge = delta_x_acc | {2'b00, rx[5:0]};
  assign dy_merge = delta_y_acc | {2'b00, rx[5:0]};

  always_comb begin
    byte_index_next   = byte_index;
    left_button_next  = left_button;
    right_button_next = right_button;
    delta_x_acc_next  = delta_x_acc;
    delta_y_acc_next  = delta_y_acc;
    cur_col_next      = cur_col;
    cur_row_next      = cur_row;
    moved             = 1'b0;
    dx                = delta_x_acc;
    dy                = '0;
    if (rx[BIT_SYNC]) begin
      // sync byte: restart packet, latch buttons and the delta top bits
      byte_index_next   = IDX_DX;
      left_button_next  = cfg.swap_buttons ? rx[BIT_B4] : rx[BIT_B5];
      right_button_next = cfg.swap_buttons ? rx[BIT_B5] : rx[BIT_B4];
      delta_x_acc_next  = {rx[1:0], 6'b000000};
      delta_y_acc_next  = {rx[3:2], 6'b000000};
    end else if (byte_index == IDX_DX) begin
      byte_index_next  = IDX_DY;
      delta_x_acc_next = cfg.invert_x ? DELTA_W'(-dx_merge) : dx_merge;
    end else if (byte_index == IDX_DY) begin
      byte_index_next  = IDX_DONE;
      delta_y_acc_next = cfg.invert_y ? DELTA_W'(-dy_merge) : dy_merge;
      dy               = delta_y_acc_next;
      moved            = 1'b1;
      if (cfg.swap_axes) begin
        cur_col_next = move_clip(cur_col, dy, cfg.screen_width);
        cur_row_next = move_clip(cur_row, dx, cfg.screen_height);
      end else begin
        cur_col_next = move_clip(cur_col, dx, cfg.screen_width);
        cur_row_next = move_clip(cur_row, dy, cfg.screen_height);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= IDX_DX;
      left_button  <= 1'b0;
      right_button <= 1'b0;
      delta_x_acc  <= '0;
      delta_y_acc  <= '0;
      cur_col      <= POS_BITS'(RESET_WIDTH / 2);
      cur_row      <= POS_BITS'(RESET_HEIGHT / 2);
    end else if (fire) begin
      byte_index   <= byte_index_next;
      left_button  <= left_button_next;
      right_button <= right_button_next;
      delta_x_acc  <= delta_x_acc_next;
      delta_y_acc  <= delta_y_acc_next;
      cur_col      <= cur_col_next;
      cur_row      <= cur_row_next;
    end
  end

  assign res.col        = cur_col_next;
  assign res.row        = cur_row_next;
  assign res.left_down  = left_button_next;
  assign res.right_down = right_button_next;
  assign res.moved      = moved;
  assign res.delta_x    = delta_x_acc_next;
  assign res.delta_y    = delta_y_acc_next;

  a_sync_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && rx[BIT_SYNC] |=> byte_index == IDX_DX)
    else $error("sync byte did not restart the packet");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(cur_col) && $stable(cur_row) && $stable(byte_index))
    else $error("packet state changed without a byte");

  a_cursor_moves_on_third: assert property (@(posedge clk) disable iff (rst)
    fire && !moved |=> $stable(cur_col) && $stable(cur_row))
    else $error("cursor changed on a byte that did not complete a packet");

  a_index_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_index == IDX_DX || byte_index == IDX_DY || byte_index == IDX_DONE)
    else $error("byte index left its range");

endmodule

FILE: rtl/core/serial_mouse_cursor_tracker_core.sv
// Top level of the serial mouse cursor tracker: input register, output
// register and handshake. Depends on smct_pkg, smct_cfg and smct_tracker.
//
// Usage:
//   Received bytes enter on in_valid/rx_byte; a byte is taken at a clock
//   edge with in_valid high and in_stall low. Each byte yields exactly one
//   item on out_valid with the cursor (pos_x, pos_y), the button states,
//   moved (set when the byte completed a three-byte packet) and the packet
//   deltas after inversion. The receiver holds out_stall high to hold an
//   item; the item and out_valid stay put until out_stall drops.
//   A byte taken into the input register moves on to the output register.
//   Throughput: one byte per cycle while out_stall is low; the packet state
//   and cursor update sit between the input register and the output register.
//   A stalled output backs up into the input register, and in_stall rises
//   only once both registers hold an item.
//   Configuration: cfg_valid/cfg_index/cfg_data, always ready; write only
//   while no byte is in flight. Unknown indexes are ignored.
//   Reset (rst, synchronous): registers return to 320x240, options off,
//   cursor at 160,120, byte index at the X delta byte, both registers empty.
module serial_mouse_cursor_tracker_core
  import smct_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [POS_OUT_W-1:0]      pos_x,
  output logic [POS_OUT_W-1:0]      pos_y,
  output logic                      left_down,
  output logic                      right_down,
  output logic                      moved,
  output logic signed [DELTA_W-1:0] delta_x_out,
  output logic signed [DELTA_W-1:0] delta_y_out,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cfg_t        cfg;
  result_t     res;
  result_t     out_q;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        out_load;
  logic        s1_adv;
  logic        in_take;

  smct_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  smct_tracker u_tracker (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_adv),
    .rx   (s1_byte),
    .cfg  (cfg),
    .res  (res)
  );

  assign out_load = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_load;
  assign in_stall = s1_valid && !out_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign pos_x       = POS_OUT_W'(out_q.col);
  assign pos_y       = POS_OUT_W'(out_q.row);
  assign left_down   = out_q.left_down;
  assign right_down  = out_q.right_down;
  assign moved       = out_q.moved;
  assign delta_x_out = out_q.delta_x;
  assign delta_y_out = out_q.delta_y;

endmodule
